// ===== sv/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and fixed constants of the text console cursor engine:
// field widths, action and character codes, the classified command word.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    // field widths of the transfer payload
    localparam int ACTION_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int COLUMN_W    = 7;
    localparam int ROW_FIELD_W = 5;
    localparam int LINEAR_W    = 11;
    localparam int CELL_W      = 16;

    // configuration port
    localparam int                PADDR_W        = 2;
    localparam int                PDATA_W        = 32;
    localparam logic [PADDR_W-1:0] ADDR_TEXT_ATTR = 2'd0;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUT_CHAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_CUR  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ     = 2'd3;

    // character codes with special handling
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0A;
    localparam int                TAB_STEP   = 8;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified command
    typedef enum logic [2:0] {
        K_NEWLINE,
        K_BACKSPACE,
        K_TAB,
        K_GLYPH,
        K_CLEAR,
        K_SET_CUR,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [CHAR_W-1:0]      ch;
        logic [ATTR_W-1:0]      fill;
        logic [COLUMN_W-1:0]    col;
        logic [ROW_FIELD_W-1:0] row;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/tcce_front.sv =====
// ----------------------------------------------------------------------------
// tcce_front
// Input side: takes transfers, clamps the target position, classifies the
// action and queues the command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_front
    import tcce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_hold,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [ACTION_W-1:0]    i_action,
    input  wire logic [CHAR_W-1:0]      i_char_code,
    input  wire logic [ATTR_W-1:0]      i_fill_color,
    input  wire logic [COLUMN_W-1:0]    i_column,
    input  wire logic [ROW_FIELD_W-1:0] i_row,
    output t_cmd                        o_cmd,
    output logic                        o_cmd_valid,
    input  wire logic                   i_cmd_pop
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              w_cmd;
    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;

    // clamp position and classify action
    always_comb begin
        w_cmd.ch   = i_char_code;
        w_cmd.fill = i_fill_color;
        if (32'(i_column) > COLS - 1) begin
            w_cmd.col = COLUMN_W'(COLS - 1);
        end else begin
            w_cmd.col = i_column;
        end
        if (32'(i_row) > ROWS - 1) begin
            w_cmd.row = ROW_FIELD_W'(ROWS - 1);
        end else begin
            w_cmd.row = i_row;
        end
        unique case (i_action)
            ACT_PUT_CHAR: begin
                if (i_char_code == CH_NEWLINE) begin
                    w_cmd.kind = K_NEWLINE;
                end else if (i_char_code == CH_BACKSPACE) begin
                    w_cmd.kind = K_BACKSPACE;
                end else if (i_char_code == CH_TAB) begin
                    w_cmd.kind = K_TAB;
                end else begin
                    w_cmd.kind = K_GLYPH;
                end
            end
            ACT_CLEAR:   w_cmd.kind = K_CLEAR;
            ACT_SET_CUR: w_cmd.kind = K_SET_CUR;
            default:     w_cmd.kind = K_READ;
        endcase
    end

    // queue control
    assign o_in_stall  = (r_count == QCNT_W'(QUEUE_DEPTH)) || i_hold;
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !i_cmd_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_cmd_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcce_back.sv =====
// ----------------------------------------------------------------------------
// tcce_back
// Execution side: owns the cursor, the top-row ring offset and the screen
// RAM. Carries out one command at a time and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_back
    import tcce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    input  wire logic                    i_cmd_valid,
    output logic                         o_cmd_pop,
    input  wire logic [ATTR_W-1:0]       i_text_attr,
    output logic                         o_init_busy,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [COLUMN_W-1:0]          o_cursor_column,
    output logic [ROW_FIELD_W-1:0]       o_cursor_row,
    output logic [LINEAR_W-1:0]          o_cursor_linear,
    output logic [CELL_W-1:0]            o_cell_value
);

    localparam int COL_W  = $clog2(COLS);
    localparam int COLX_W = COL_W + 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWX_W = ROW_W + 1;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LINE,
        S_CLEAR,
        S_READ,
        S_WAIT
    } t_state;

    t_state             r_state;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_line;
    logic [ROW_W-1:0]   r_top;
    logic [ADDR_W-1:0]  r_addr;
    logic [COL_W-1:0]   r_cnt;
    logic [CELL_W-1:0]  r_blank;
    logic [CELL_W-1:0]  r_cell;

    logic [COLX_W-1:0]  w_col_p1;
    logic [COLX_W-1:0]  w_tab;
    logic [ROWX_W-1:0]  w_line_p1;
    logic [COL_W-1:0]   w_nc;
    logic [ROWX_W-1:0]  w_nl;
    logic [ROW_W-1:0]   w_line_fin;
    logic               w_scroll;
    logic               w_pop_we;
    logic [ADDR_W-1:0]  w_pop_addr;
    logic [CELL_W-1:0]  w_pop_data;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [CELL_W-1:0]  w_wdata;
    logic [CELL_W-1:0]  w_rdata;
    logic               w_out_free;
    logic [ROWX_W-1:0]  w_top_p1;
    logic [ADDR_W-1:0]  w_linear;

    // logical row to physical cell address through the ring offset
    function automatic logic [ADDR_W-1:0] f_cell_addr(
        input logic [ROW_W-1:0] line,
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] top
    );
        logic [ROWX_W-1:0] phys;
        phys = {1'b0, line} + {1'b0, top};
        if (phys >= ROWX_W'(ROWS)) begin
            phys = phys - ROWX_W'(ROWS);
        end
        return ADDR_W'(phys) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_init_busy = (r_state == S_INIT);
    assign w_out_free  = !o_out_valid || !i_out_stall;

    // cursor arithmetic for the command at the head of the queue
    assign w_col_p1  = {1'b0, r_col} + 1'b1;
    assign w_tab     = ({1'b0, r_col} + COLX_W'(TAB_STEP)) & ~COLX_W'(TAB_STEP - 1);
    assign w_line_p1 = {1'b0, r_line} + 1'b1;
    assign w_rd_addr = f_cell_addr(ROW_W'(i_cmd.row), COL_W'(i_cmd.col), r_top);

    always_comb begin
        w_nc       = r_col;
        w_nl       = {1'b0, r_line};
        w_pop_we   = 1'b0;
        w_pop_addr = f_cell_addr(r_line, r_col, r_top);
        w_pop_data = {i_text_attr, i_cmd.ch};
        unique case (i_cmd.kind)
            K_NEWLINE: begin
                w_nc = '0;
                w_nl = w_line_p1;
            end
            K_BACKSPACE: begin
                if (r_col != '0) begin
                    w_nc = r_col - 1'b1;
                end else if (r_line != '0) begin
                    w_nc = COL_W'(COLS - 1);
                    w_nl = {1'b0, r_line} - 1'b1;
                end
                w_pop_we   = 1'b1;
                w_pop_addr = f_cell_addr(w_nl[ROW_W-1:0], w_nc, r_top);
                w_pop_data = {i_text_attr, CH_BLANK};
            end
            K_TAB: begin
                if (w_tab >= COLX_W'(COLS)) begin
                    w_nc = '0;
                    w_nl = w_line_p1;
                end else begin
                    w_nc = w_tab[COL_W-1:0];
                end
            end
            K_GLYPH: begin
                w_pop_we = 1'b1;
                if (w_col_p1 == COLX_W'(COLS)) begin
                    w_nc = '0;
                    w_nl = w_line_p1;
                end else begin
                    w_nc = w_col_p1[COL_W-1:0];
                end
            end
            K_CLEAR: begin
                w_nc = '0;
                w_nl = '0;
            end
            K_SET_CUR: begin
                w_nc = COL_W'(i_cmd.col);
                w_nl = ROWX_W'(i_cmd.row);
            end
            K_READ: begin
                w_nc = r_col;
            end
            default: begin
                w_nc = r_col;
            end
        endcase
    end

    assign w_scroll   = (w_nl == ROWX_W'(ROWS));
    assign w_line_fin = w_scroll ? ROW_W'(ROWS - 1) : w_nl[ROW_W-1:0];
    assign w_top_p1   = {1'b0, r_top} + 1'b1;
    assign w_linear   = ADDR_W'(r_line) * ADDR_W'(COLS) + ADDR_W'(r_col);

    // RAM write port: sweeps own it, otherwise the single cell of a command
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_blank;
        unique case (r_state)
            S_INIT, S_LINE, S_CLEAR: begin
                w_we = 1'b1;
            end
            S_IDLE: begin
                w_we    = o_cmd_pop && w_pop_we;
                w_waddr = w_pop_addr;
                w_wdata = w_pop_data;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    // sequencer, cursor state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_col       <= '0;
            r_line      <= '0;
            r_top       <= '0;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_blank     <= {RESET_ATTR, CH_BLANK};
            o_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall && (r_state != S_WAIT)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_addr == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_col   <= w_nc;
                        r_line  <= w_line_fin;
                        r_cell  <= '0;
                        if (i_cmd.kind == K_CLEAR) begin
                            r_top   <= '0;
                            r_addr  <= '0;
                            r_blank <= {i_cmd.fill, CH_BLANK};
                            r_state <= S_CLEAR;
                        end else if (w_scroll) begin
                            r_addr  <= ADDR_W'(r_top) * ADDR_W'(COLS);
                            r_cnt   <= '0;
                            r_blank <= {i_text_attr, CH_BLANK};
                            r_top   <= (w_top_p1 == ROWX_W'(ROWS)) ? '0 : w_top_p1[ROW_W-1:0];
                            r_state <= S_LINE;
                        end else if (i_cmd.kind == K_READ) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_LINE: begin
                    r_addr <= r_addr + 1'b1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == COL_W'(COLS - 1)) begin
                        r_state <= S_WAIT;
                    end
                end
                S_CLEAR: begin
                    if (r_addr == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_READ: begin
                    r_cell  <= w_rdata;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        o_out_valid     <= 1'b1;
                        o_cursor_column <= COLUMN_W'(r_col);
                        o_cursor_row    <= ROW_FIELD_W'(r_line);
                        o_cursor_linear <= LINEAR_W'(w_linear);
                        o_cell_value    <= r_cell;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character cell console: screen store, cursor, scroll by ring offset.
// ----------------------------------------------------------------------------
// A COLS x ROWS screen of 16-bit cells (attribute high, character low) with a
// text cursor. Each input transfer gives exactly one result transfer carrying
// the cursor and, for read cell, the cell. A front end clamps and classifies
// actions into a two-entry command queue; a back end executes them against a
// single-port-write screen RAM. Read cell takes a registered RAM read; a put
// that scrolls blanks the new bottom line one cell per cycle, and clear screen
// runs a fill sweep over the whole screen. After reset the block runs a
// clearing pass over all ROWS*COLS cells (2000 at 80x25) before it takes
// input; register writes are taken throughout.
`default_nettype none

module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [ACTION_W-1:0]    i_action,
    input  wire logic [CHAR_W-1:0]      i_char_code,
    input  wire logic [ATTR_W-1:0]      i_fill_color,
    input  wire logic [COLUMN_W-1:0]    i_column,
    input  wire logic [ROW_FIELD_W-1:0] i_row,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [COLUMN_W-1:0]         o_cursor_column,
    output logic [ROW_FIELD_W-1:0]      o_cursor_row,
    output logic [LINEAR_W-1:0]         o_cursor_linear,
    output logic [CELL_W-1:0]           o_cell_value
);

    logic [ATTR_W-1:0] r_text_attr;
    t_cmd              w_cmd;
    logic              w_cmd_valid;
    logic              w_cmd_pop;
    logic              w_init_busy;

    // text attribute register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TEXT_ATTR) ? PDATA_W'(r_text_attr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= RESET_ATTR;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_TEXT_ATTR)) begin
            r_text_attr <= pwdata[ATTR_W-1:0];
        end
    end

    // input side and command queue
    tcce_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (w_init_busy),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_fill_color (i_fill_color),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_cmd        (w_cmd),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_pop    (w_cmd_pop)
    );

    // execution side and screen store
    tcce_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_pop       (w_cmd_pop),
        .i_text_attr     (r_text_attr),
        .o_init_busy     (w_init_busy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_linear (o_cursor_linear),
        .o_cell_value    (o_cell_value)
    );

`ifndef NO_ASSERTIONS
    // no transfer is taken while the clearing pass runs
    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> o_in_stall)
        else $error("input taken during clearing pass");

    // back end never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command queue underflow");

    // reported column stays on screen
    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_column) < COLS))
        else $error("cursor column off screen");
`endif

endmodule

`default_nettype wire
